[rtl/core/swe_pkg.sv]
// Package for the source waveform evaluator: widths, register indices,
// state codes, sine polynomial coefficients and saturation helper.
// Depends on nothing.
package swe_pkg;

  localparam int unsigned TIME_BITS       = 48;
  localparam int unsigned PWL_POINTS      = 16;
  localparam int unsigned IDX_BITS        = $clog2(PWL_POINTS);
  localparam int unsigned LEN_BITS        = IDX_BITS + 1;
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned POS_BITS        = SINE_TABLE_BITS - 2;
  localparam int unsigned LEVEL_BITS      = 32;
  localparam int unsigned CFG_BITS        = 48;
  localparam int unsigned CFG_IDX_BITS    = 3;
  localparam int unsigned S_TDATA_BITS    = 136;
  localparam int unsigned MUL_BITS        = 34;
  localparam int unsigned DIV_BITS        = TIME_BITS + 1;
  localparam int unsigned CNT_BITS        = 6;
  localparam int unsigned MAG_BITS        = 33;
  localparam int unsigned PART_BITS       = 24;

  localparam logic [CNT_BITS-1:0] DIV_PULSE_STEPS = CNT_BITS'(DIV_BITS);
  localparam logic [CNT_BITS-1:0] DIV_PWL_STEPS   = CNT_BITS'(MAG_BITS);

  // waveform modes
  localparam logic [1:0] MODE_CONST = 2'd0;
  localparam logic [1:0] MODE_SINE  = 2'd1;
  localparam logic [1:0] MODE_PULSE = 2'd2;
  localparam logic [1:0] MODE_PWL   = 2'd3;

  // register indices
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DC_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_AMPLITUDE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_START     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_COUNT     = 3'd7;

  typedef enum logic [23:0] {
    ST_IDLE   = 24'd1 << 0,
    ST_LD_RD  = 24'd1 << 1,
    ST_LD_WR  = 24'd1 << 2,
    ST_SN_PH  = 24'd1 << 3,
    ST_SN_X   = 24'd1 << 4,
    ST_SN_X2  = 24'd1 << 5,
    ST_SN_H   = 24'd1 << 6,
    ST_SN_HW  = 24'd1 << 7,
    ST_SN_S   = 24'd1 << 8,
    ST_SN_Q   = 24'd1 << 9,
    ST_SN_A   = 24'd1 << 10,
    ST_SN_R   = 24'd1 << 11,
    ST_PU_E   = 24'd1 << 12,
    ST_DIV    = 24'd1 << 13,
    ST_PU_CMP = 24'd1 << 14,
    ST_PW_A0  = 24'd1 << 15,
    ST_PW_B0  = 24'd1 << 16,
    ST_PW_BL  = 24'd1 << 17,
    ST_PW_SC  = 24'd1 << 18,
    ST_PW_M0  = 24'd1 << 19,
    ST_PW_M1  = 24'd1 << 20,
    ST_PW_M2  = 24'd1 << 21,
    ST_PW_FIN = 24'd1 << 22,
    ST_OUT    = 24'd1 << 23
  } state_e;

  // Horner coefficients of sin(x*pi/2) in Q30, innermost first, outermost last
  function automatic logic [31:0] horner_coef(input logic [1:0] k);
    logic [31:0] c;
    case (k)
      2'd0:    c = 32'd5026995;
      2'd1:    c = 32'd85569306;
      2'd2:    c = 32'd693598668;
      default: c = 32'd1686629713;
    endcase
    return c;
  endfunction

  localparam logic [30:0] COEF_TOP = 31'd172272;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (v < -35'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

[rtl/core/source_waveform_evaluator.sv]
// Source waveform evaluator top level: constant, sine, pulse and piecewise-linear
// waveforms worked out by one shared multiplier and one bit-serial divider.
// Depends on swe_pkg.

// An evaluate beat (tuser 0) returns one result beat holding the Q16.16 level at
// tick time_req and a status flag; a load beat (tuser 1) writes one piecewise
// point and returns nothing. One item is in flight at a time: s_axis_tready is
// high only while the sequencer is idle. Per item: constant goes straight to the
// output; load reads the previous point, then writes; sine makes eight passes
// through the shared 34x34 multiplier, each Horner step a multiply state then a
// write-back state; pulse runs a 49-step restoring divider for the period
// (skipped before the start time or with a zero period); piecewise scans the
// segments at one table read per cycle, then does a two-part multiply and a
// 33-step division (skipped for an empty or bad table). The result sits in an
// output register, so the next beat is accepted while it waits. Configuration
// is written through cfg_we_i/cfg_idx_i/cfg_data_i, by the user only while idle,
// which the block does not enforce. The point table needs no clearing after reset.
module source_waveform_evaluator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [47:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // time_req[47:0], point_index[51:48], point_time[99:52], point_value[131:100]
  input  logic [135:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // op
  input  logic         s_axis_tlast,   // point_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,   // level_out[31:0]
  output logic         m_axis_tuser    // status
);

  localparam int unsigned TB = swe_pkg::TIME_BITS;
  localparam int unsigned IB = swe_pkg::IDX_BITS;
  localparam int unsigned LB = swe_pkg::LEN_BITS;
  localparam int unsigned MB = swe_pkg::MUL_BITS;
  localparam int unsigned DB = swe_pkg::DIV_BITS;
  localparam int unsigned AB = swe_pkg::MAG_BITS;
  localparam int unsigned PB = swe_pkg::PART_BITS;
  localparam int unsigned SB = swe_pkg::SINE_TABLE_BITS;
  localparam int unsigned QB = swe_pkg::POS_BITS;
  localparam int unsigned EB = TB + 32;

  swe_pkg::state_e state_q, state_d;

  // configuration
  logic [1:0]         mode_q;
  logic signed [31:0] dc_q, amp_q;
  logic [31:0]        phase_q, count_q;
  logic signed [47:0] start_q;
  logic [46:0]        width_q, period_q;

  // item and table control
  logic [LB-1:0] len_q, len_d;
  logic          bad_q, bad_d;
  logic [IB-1:0] j_q, j_d;
  logic [1:0]    k_q, k_d;
  logic [swe_pkg::CNT_BITS-1:0] cnt_q, cnt_d;
  logic          mvalid_q, mvalid_d;

  // payload
  logic [TB-1:0]      t_q, pt_q;
  logic [IB-1:0]      idx_q;
  logic signed [31:0] pv_q;
  logic               plast_q;
  logic [EB-1:0]      mem [swe_pkg::PWL_POINTS];
  logic [EB-1:0]      rd_q;
  logic [IB-1:0]      raddr;
  logic               we;
  logic signed [2*MB-1:0] mul_q;
  logic signed [MB-1:0]   ma, mb;
  logic [30:0] x_q, x_d, x2_q, x2_d, p_q, p_d;
  logic [1:0]  quad_q, quad_d;
  logic signed [17:0] samp_q, samp_d;
  logic [TB-1:0] div_q, div_d, rem_q, rem_d, b_q, b_d;
  logic [DB-1:0] dq_q, dq_d;
  logic [TB-1:0] prev_t_q, prev_t_d;
  logic signed [31:0] prev_l_q, prev_l_d, fb_q, fb_d, res_q, res_d;
  logic signed [31:0] base_q, base_d;
  logic [AB-1:0] a_q, a_d;
  logic          neg_q, neg_d, rst_q, rst_d;
  logic [AB+PB-1:0] p0_q, p0_d;
  logic [31:0]   mdata_q, mdata_d;
  logic          muser_q, muser_d;

  // combinational helpers
  logic [TB-1:0]      rd_t;
  logic signed [31:0] rd_l;
  logic [IB-1:0]      last;
  logic [SB-1:0]      sidx;
  logic [QB:0]        xn;
  logic [30:0]        xc;
  logic [32:0]        srnd;
  logic [18:0]        q16w;
  logic [16:0]        q16;
  logic signed [49:0] total;
  logic [DB-1:0]      e;
  logic [TB-1:0]      negs;
  logic [TB:0]        sh;
  logic [EB:0]        prod;
  logic signed [32:0] dv;
  logic signed [34:0] sum;
  logic signed [32:0] padd;

  assign rd_t = rd_q[TB-1:0];
  assign rd_l = rd_q[EB-1:TB];
  assign last = IB'(len_q - LB'(1));
  assign s_axis_tready = (state_q == swe_pkg::ST_IDLE);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = muser_q;

  // sine index, quadrant mirror
  assign sidx = mul_q[31:32-SB];
  assign xn   = sidx[QB] ? ((QB+1)'(1) << QB) - {1'b0, sidx[QB-1:0]}
                         : {1'b0, sidx[QB-1:0]};
  assign xc   = 31'(xn) << (30 - QB);
  assign srnd = {1'b0, mul_q[61:30]} + 33'd8192;
  assign q16w = srnd[32:14];
  assign q16  = (q16w > 19'd65536) ? 17'd65536 : q16w[16:0];
  assign total = 50'(signed'({dc_q, 16'b0})) + mul_q[49:0] + 50'sd32768;
  assign negs = TB'(~start_q + 48'sd1);
  assign e    = start_q[47] ? {1'b0, t_q} + {1'b0, negs}
                            : {1'b0, t_q - start_q[TB-1:0]};
  assign sh   = {rem_q, dq_q[DB-1]};
  assign prod = {{(EB+1-AB-PB){1'b0}}, p0_q} + ((EB+1)'(mul_q[AB+PB-1:0]) << PB);
  assign dv   = 33'(rd_l) - 33'(prev_l_q);
  assign padd = 33'(dc_q) + 33'(amp_q);

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    bad_d    = bad_q;
    j_d      = j_q;
    k_d      = k_q;
    cnt_d    = cnt_q;
    mvalid_d = mvalid_q;
    x_d = x_q; x2_d = x2_q; p_d = p_q; quad_d = quad_q; samp_d = samp_q;
    div_d = div_q; rem_d = rem_q; dq_d = dq_q; b_d = b_q;
    prev_t_d = prev_t_q; prev_l_d = prev_l_q; fb_d = fb_q; res_d = res_q;
    base_d = base_q; a_d = a_q; neg_d = neg_q; rst_d = rst_q; p0_d = p0_q;
    mdata_d = mdata_q; muser_d = muser_q;
    ma = '0; mb = '0; raddr = '0; we = 1'b0;
    sum = '0;

    // drop the result beat once taken
    if (mvalid_q && m_axis_tready) mvalid_d = 1'b0;

    case (state_q)
      swe_pkg::ST_IDLE: begin
        rst_d = 1'b0;
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            state_d = swe_pkg::ST_LD_RD;
          end else begin
            case (mode_q)
              swe_pkg::MODE_CONST: begin
                res_d = dc_q; state_d = swe_pkg::ST_OUT;
              end
              swe_pkg::MODE_SINE:  state_d = swe_pkg::ST_SN_PH;
              swe_pkg::MODE_PULSE: state_d = swe_pkg::ST_PU_E;
              default: begin
                if (len_q == '0 || bad_q) begin
                  res_d = '0; rst_d = 1'b1; state_d = swe_pkg::ST_OUT;
                end else begin
                  state_d = swe_pkg::ST_PW_A0;
                end
              end
            endcase
          end
        end
      end
      swe_pkg::ST_LD_RD: begin
        raddr = IB'(idx_q - IB'(1));
        state_d = swe_pkg::ST_LD_WR;
      end
      swe_pkg::ST_LD_WR: begin
        we = 1'b1;
        if (idx_q == '0) begin
          bad_d = 1'b0; len_d = '0;
        end else if (pt_q <= rd_t) begin
          bad_d = 1'b1;
        end
        if (plast_q) len_d = LB'(idx_q) + LB'(1);
        state_d = swe_pkg::ST_IDLE;
      end
      // sine
      swe_pkg::ST_SN_PH: begin
        ma = MB'(phase_q);
        mb = MB'(t_q[31:0] - start_q[31:0]);
        state_d = swe_pkg::ST_SN_X;
      end
      swe_pkg::ST_SN_X: begin
        x_d = xc; quad_d = sidx[SB-1:SB-2];
        ma = MB'(xc); mb = MB'(xc);
        state_d = swe_pkg::ST_SN_X2;
      end
      swe_pkg::ST_SN_X2: begin
        x2_d = mul_q[60:30]; p_d = swe_pkg::COEF_TOP; k_d = '0;
        state_d = swe_pkg::ST_SN_H;
      end
      swe_pkg::ST_SN_H: begin
        ma = MB'(x2_q); mb = MB'(p_q);
        state_d = swe_pkg::ST_SN_HW;
      end
      swe_pkg::ST_SN_HW: begin
        p_d = 31'(swe_pkg::horner_coef(k_q) - mul_q[61:30]);
        k_d = k_q + 2'd1;
        state_d = (k_q == 2'd3) ? swe_pkg::ST_SN_S : swe_pkg::ST_SN_H;
      end
      swe_pkg::ST_SN_S: begin
        ma = MB'(x_q); mb = MB'(p_q);
        state_d = swe_pkg::ST_SN_Q;
      end
      swe_pkg::ST_SN_Q: begin
        samp_d = quad_q[1] ? -18'(signed'({1'b0, q16})) : 18'(signed'({1'b0, q16}));
        state_d = swe_pkg::ST_SN_A;
      end
      swe_pkg::ST_SN_A: begin
        ma = MB'(amp_q); mb = MB'(samp_q);
        state_d = swe_pkg::ST_SN_R;
      end
      swe_pkg::ST_SN_R: begin
        res_d = swe_pkg::sat32(35'(total >>> 16));
        state_d = swe_pkg::ST_OUT;
      end
      // pulse
      swe_pkg::ST_PU_E: begin
        if (!start_q[47] && t_q < start_q[TB-1:0]) begin
          res_d = dc_q; state_d = swe_pkg::ST_OUT;
        end else if (period_q == '0) begin
          res_d = (e < DB'(width_q)) ? swe_pkg::sat32(35'(padd)) : dc_q;
          state_d = swe_pkg::ST_OUT;
        end else begin
          div_d = TB'(period_q); rem_d = '0; dq_d = e;
          cnt_d = swe_pkg::DIV_PULSE_STEPS;
          state_d = swe_pkg::ST_DIV;
        end
      end
      swe_pkg::ST_DIV: begin
        // one quotient bit a cycle
        if (sh >= {1'b0, div_q}) begin
          rem_d = TB'(sh - {1'b0, div_q});
          dq_d  = {dq_q[DB-2:0], 1'b1};
        end else begin
          rem_d = sh[TB-1:0];
          dq_d  = {dq_q[DB-2:0], 1'b0};
        end
        cnt_d = cnt_q - swe_pkg::CNT_BITS'(1);
        if (cnt_q == swe_pkg::CNT_BITS'(1)) begin
          state_d = (mode_q == swe_pkg::MODE_PULSE) ? swe_pkg::ST_PU_CMP
                                                    : swe_pkg::ST_PW_FIN;
        end
      end
      swe_pkg::ST_PU_CMP: begin
        if (count_q != '0 && dq_q >= DB'(count_q)) res_d = dc_q;
        else if (rem_q < TB'(width_q))             res_d = swe_pkg::sat32(35'(padd));
        else                                       res_d = dc_q;
        state_d = swe_pkg::ST_OUT;
      end
      // piecewise linear
      swe_pkg::ST_PW_A0: begin
        raddr = '0;
        state_d = swe_pkg::ST_PW_B0;
      end
      swe_pkg::ST_PW_B0: begin
        prev_t_d = rd_t; prev_l_d = rd_l;
        raddr = last;
        if (t_q <= rd_t) begin
          res_d = rd_l; state_d = swe_pkg::ST_OUT;
        end else begin
          state_d = swe_pkg::ST_PW_BL;
        end
      end
      swe_pkg::ST_PW_BL: begin
        raddr = IB'(1);
        fb_d = rd_l; j_d = IB'(1);
        if (t_q >= rd_t) begin
          res_d = rd_l; state_d = swe_pkg::ST_OUT;
        end else begin
          state_d = swe_pkg::ST_PW_SC;
        end
      end
      swe_pkg::ST_PW_SC: begin
        raddr = j_q + IB'(1);
        if (t_q >= prev_t_q && t_q <= rd_t && rd_t > prev_t_q) begin
          neg_d  = dv[32];
          a_d    = dv[32] ? AB'(-dv) : AB'(dv);
          base_d = prev_l_q;
          b_d    = t_q - prev_t_q;
          div_d  = rd_t - prev_t_q;
          state_d = swe_pkg::ST_PW_M0;
        end else begin
          prev_t_d = rd_t; prev_l_d = rd_l;
          j_d = j_q + IB'(1);
          if (j_q == last) begin
            res_d = fb_q; state_d = swe_pkg::ST_OUT;
          end
        end
      end
      swe_pkg::ST_PW_M0: begin
        ma = MB'(a_q); mb = MB'(b_q[PB-1:0]);
        state_d = swe_pkg::ST_PW_M1;
      end
      swe_pkg::ST_PW_M1: begin
        p0_d = mul_q[AB+PB-1:0];
        ma = MB'(a_q); mb = MB'(b_q[TB-1:PB]);
        state_d = swe_pkg::ST_PW_M2;
      end
      swe_pkg::ST_PW_M2: begin
        // high part is already below the divisor
        rem_d = prod[EB:AB];
        dq_d  = {prod[AB-1:0], {(DB-AB){1'b0}}};
        cnt_d = swe_pkg::DIV_PWL_STEPS;
        state_d = swe_pkg::ST_DIV;
      end
      swe_pkg::ST_PW_FIN: begin
        sum = neg_q ? 35'(base_q) - 35'({2'b0, dq_q[AB-1:0]})
                    : 35'(base_q) + 35'({2'b0, dq_q[AB-1:0]});
        res_d = swe_pkg::sat32(sum);
        state_d = swe_pkg::ST_OUT;
      end
      swe_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1; mdata_d = res_q; muser_d = rst_q;
          state_d = swe_pkg::ST_IDLE;
        end
      end
      default: state_d = swe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= swe_pkg::ST_IDLE;
      mode_q   <= swe_pkg::MODE_CONST;
      dc_q     <= '0;
      amp_q    <= '0;
      phase_q  <= 32'd1;
      start_q  <= '0;
      width_q  <= 47'd1;
      period_q <= 47'd2;
      count_q  <= '0;
      len_q    <= '0;
      bad_q    <= 1'b0;
      j_q      <= '0;
      k_q      <= '0;
      cnt_q    <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      bad_q    <= bad_d;
      j_q      <= j_d;
      k_q      <= k_d;
      cnt_q    <= cnt_d;
      mvalid_q <= mvalid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          swe_pkg::REG_MODE:      mode_q   <= cfg_data_i[1:0];
          swe_pkg::REG_DC_LEVEL:  dc_q     <= cfg_data_i[31:0];
          swe_pkg::REG_AMPLITUDE: amp_q    <= cfg_data_i[31:0];
          swe_pkg::REG_PHASE:     phase_q  <= cfg_data_i[31:0];
          swe_pkg::REG_START:     start_q  <= cfg_data_i;
          swe_pkg::REG_WIDTH:     width_q  <= cfg_data_i[46:0];
          swe_pkg::REG_PERIOD:    period_q <= cfg_data_i[46:0];
          swe_pkg::REG_COUNT:     count_q  <= cfg_data_i[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      t_q     <= s_axis_tdata[47:0];
      idx_q   <= s_axis_tdata[51:48];
      pt_q    <= s_axis_tdata[99:52];
      pv_q    <= s_axis_tdata[131:100];
      plast_q <= s_axis_tlast;
    end
    mul_q    <= ma * mb;
    x_q      <= x_d;
    x2_q     <= x2_d;
    p_q      <= p_d;
    quad_q   <= quad_d;
    samp_q   <= samp_d;
    div_q    <= div_d;
    rem_q    <= rem_d;
    dq_q     <= dq_d;
    b_q      <= b_d;
    prev_t_q <= prev_t_d;
    prev_l_q <= prev_l_d;
    fb_q     <= fb_d;
    res_q    <= res_d;
    base_q   <= base_d;
    a_q      <= a_d;
    neg_q    <= neg_d;
    rst_q    <= rst_d;
    p0_q     <= p0_d;
    mdata_q  <= mdata_d;
    muser_q  <= muser_d;
  end

  // point table: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (we) mem[idx_q] <= {pv_q, pt_q};
    rd_q <= mem[raddr];
  end

endmodule
